// ===== rtl/sdt_pkg.sv =====
// shared types and constants for the sorted descending table
package sdt_pkg;

  localparam int CAPACITY = 16;
  localparam int FILL_W   = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int CNT_W    = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  // low bits of the fill count, zero-extended when the count is narrow
  function automatic logic [CNT_W-1:0] count_bits(input logic [FILL_W-1:0] f);
    logic [FILL_W+CNT_W-1:0] wide;
    wide = {{CNT_W{1'b0}}, f};
    return wide[CNT_W-1:0];
  endfunction

endpackage

// ===== rtl/sdt_ctrl.sv =====
// controller state machine for the sorted descending table
module sdt_ctrl import sdt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output logic    out_valid,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    cmd       = '0;
    busy      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        busy      = 1'b1;
        cmd.exec  = 1'b1;
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = valid_r;

endmodule

// ===== rtl/sdt_datapath.sv =====
// compare-and-shift cell array, fill count and result registers
module sdt_datapath import sdt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  input  logic [1:0]              in_op,
  input  logic signed [VAL_W-1:0] in_value,
  output logic [1:0]              out_status,
  output logic [CNT_W-1:0]        out_entry_count
);

  logic signed [VAL_W-1:0] slots_r [CAPACITY];
  logic signed [VAL_W-1:0] ins_val [CAPACITY];
  logic signed [VAL_W-1:0] del_val [CAPACITY];
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  op_t                     op_r;
  logic signed [VAL_W-1:0] value_r;
  status_t                 status_r, status_nxt;
  logic [CNT_W-1:0]        count_r;
  logic [CAPACITY-1:0]     gt, eq;
  logic                    full, found, do_ins, do_del;

  // per-cell compares against the request value
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (FILL_W'(i) < fill_r) && (slots_r[i] > value_r);
      eq[i] = (FILL_W'(i) < fill_r) && (slots_r[i] == value_r);
    end
  end

  // greater entries form a prefix, so equal entries sit right after it
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign ins_val[g] = gt[g] ? slots_r[g] : value_r;
      end else begin : g_rest
        assign ins_val[g] = gt[g]     ? slots_r[g]   :
                            gt[g - 1] ? value_r      : slots_r[g - 1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign del_val[g] = slots_r[g];
      end else begin : g_inner
        assign del_val[g] = gt[g] ? slots_r[g] : slots_r[g + 1];
      end
    end
  endgenerate

  assign full  = (fill_r == FILL_W'(CAPACITY));
  assign found = |eq;

  always_comb begin
    fill_nxt   = fill_r;
    status_nxt = ST_DONE;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    unique case (op_r)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          do_ins   = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end
      OP_SEARCH: begin
        if (!found) status_nxt = ST_MISS;
      end
      OP_DELETE: begin
        if (!found) begin
          status_nxt = ST_MISS;
        end else begin
          do_del   = 1'b1;
          fill_nxt = fill_r - 1'b1;
        end
      end
      OP_CLEAR: fill_nxt = '0;
      default:  fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.exec) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_op);
      value_r <= in_value;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      count_r  <= count_bits(fill_nxt);
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_ins) slots_r[i] <= ins_val[i];
        else if (do_del) slots_r[i] <= del_val[i];
      end
    end
  end

  assign out_status      = status_r;
  assign out_entry_count = count_r;

endmodule

// ===== rtl/sorted_descending_table.sv =====
// top level of the sorted descending table
// holds up to CAPACITY (package constant, 16) signed 32-bit values in
// descending order and serves insert, search, delete-first-match and clear
// requests. an item is taken when start is high and busy is low; every item
// gives exactly one result, shown for one cycle with out_valid high. the
// receiver cannot stall, so results must be taken when they appear. each
// item is handled by capturing the request, then by the compare-and-shift
// pass over all cells, which runs in parallel and does not depend on how full
// the table is. busy is high during that pass, so a new item is not taken
// until it is over, and the result of one item is on the outputs in the
// cycle the next item is taken.
// out_status: 0 done or found, 1 not found, 2 table full (insert refused);
// out_entry_count: low five bits of the number of values after the request
module sorted_descending_table import sdt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // request channel
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_op,
  input  logic signed [VAL_W-1:0] in_value,
  // result channel
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [CNT_W-1:0]        out_entry_count
);

  // command bundle from the controller
  dp_cmd_t cmd;

  // sequences capture, execute and the result strobe
  sdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // the table cells, fill count and result registers
  sdt_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_op           (in_op),
    .in_value        (in_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

endmodule
